>>> hdl/psfh_pkg.sv
package psfh_pkg;

  localparam int SPECTRA_BINS_DEF = 64;
  localparam int FLOW_BINS_DEF    = 32;

  localparam logic [15:0] SPEC_W_RST = 16'd410;
  localparam logic [15:0] FLOW_W_RST = 16'd819;

  localparam int SQ_W = 47;
  localparam int PT_W = 24;

  typedef enum logic {
    CFG_SPEC_W = 1'b0,
    CFG_FLOW_W = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_PION = 2'd0,
    CLS_KAON = 2'd1,
    CLS_NUC  = 2'd2,
    CLS_NONE = 2'd3
  } cls_t;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    op_t             op;
    cls_t            cls;
    logic [SQ_W-1:0] xx;
    logic [SQ_W-1:0] yy;
    logic [1:0]      rsp;
    logic [5:0]      rbin;
  } qword_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [SQ_W:0] win_lo_sq(input cls_t c);
    logic [SQ_W:0] r;
    if (c == CLS_NUC) r = 48'd4194304;
    else              r = 48'd670761;
    return r;
  endfunction

  function automatic logic [SQ_W:0] win_hi_sq(input cls_t c);
    logic [SQ_W:0] r;
    if (c == CLS_NUC) r = 48'd104857600;
    else              r = 48'd67108864;
    return r;
  endfunction

endpackage

>>> hdl/particle_spectra_flow_histogrammer.sv
// particle spectra and flow histogrammer
// input channel: a word is taken at a clock edge with start high and busy low.
//   operation 0 adds one particle (species code, mom_x, mom_y) to the pt-bin
//   spectrum and flow histograms and the windowed species sums of its species;
//   operation 1 reads one bin of one species plus that species' windowed sums.
// result channel: one word per input word, held for one cycle with out_valid
//   high; the receiver cannot stall, so results are never held back.
// config port: cfg_we writes cfg_wdata to bin width register cfg_index at once.
// path: a read skips the square root and division and goes straight to the
//   address and update states; an accumulate runs the 24-step square root and
//   the 24-step shared division pass (both bin divisions and the cos(2phi)
//   division run side by side); an ignored particle is answered from idle.
// overlap: the front squares momenta while the back works on the previous
//   word; a two-word queue sits between, so a steady stream of accumulates
//   is limited by the back, and a stream of reads is limited by the front.
// reset: all histograms and sums are cleared; a clearing pass over all
//   3*max(SPECTRA_BINS, FLOW_BINS) entries (192 by default) follows reset with
//   busy held high. Width registers return to 410 and 819.
module particle_spectra_flow_histogrammer #(
  parameter int SPECTRA_BINS = psfh_pkg::SPECTRA_BINS_DEF,
  parameter int FLOW_BINS    = psfh_pkg::FLOW_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic signed [23:0] in_species_code,
  input  logic signed [23:0] in_mom_x,
  input  logic signed [23:0] in_mom_y,
  input  logic [1:0]         in_read_species,
  input  logic [5:0]         in_read_bin,
  output logic               out_valid,
  output logic [1:0]         out_class_found,
  output logic [31:0]        out_spectrum_count,
  output logic signed [47:0] out_flow_sum,
  output logic [31:0]        out_flow_count,
  output logic [47:0]        out_mean_pt_sum,
  output logic [31:0]        out_mean_pt_count,
  output logic signed [47:0] out_mean_flow_sum,
  output logic [31:0]        out_mean_flow_count,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0]          spec_w_r, flow_w_r;
  logic                 accept, front_busy, q_push, q_pop, q_full, q_valid;
  psfh_pkg::qword_t     push_word, pop_word;
  psfh_pkg::back_stat_t stat;

  assign busy   = front_busy || stat.clearing;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_w_r <= psfh_pkg::SPEC_W_RST;
      flow_w_r <= psfh_pkg::FLOW_W_RST;
    end else if (cfg_we) begin
      if (psfh_pkg::cfg_idx_t'(cfg_index) == psfh_pkg::CFG_SPEC_W) spec_w_r <= cfg_wdata;
      else                                                         flow_w_r <= cfg_wdata;
    end
  end

  psfh_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_operation    (in_operation),
    .in_species_code (in_species_code),
    .in_mom_x        (in_mom_x),
    .in_mom_y        (in_mom_y),
    .in_read_species (in_read_species),
    .in_read_bin     (in_read_bin),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_word          (push_word),
    .front_busy      (front_busy)
  );

  psfh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_word  (pop_word)
  );

  psfh_back #(
    .SPECTRA_BINS (SPECTRA_BINS),
    .FLOW_BINS    (FLOW_BINS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .spec_w              (spec_w_r),
    .flow_w              (flow_w_r),
    .q_valid             (q_valid),
    .q_word              (pop_word),
    .q_pop               (q_pop),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_class_found     (out_class_found),
    .out_spectrum_count  (out_spectrum_count),
    .out_flow_sum        (out_flow_sum),
    .out_flow_count      (out_flow_count),
    .out_mean_pt_sum     (out_mean_pt_sum),
    .out_mean_pt_count   (out_mean_pt_count),
    .out_mean_flow_sum   (out_mean_flow_sum),
    .out_mean_flow_count (out_mean_flow_count)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("no clearing pass after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after accept");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_class_found == psfh_pkg::CLS_NONE |->
      out_spectrum_count == 32'd0 && out_flow_count == 32'd0 &&
      out_mean_pt_count == 32'd0 && out_mean_flow_count == 32'd0)
    else $error("ignored word carries data");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_valid)
    else $error("result during clearing pass");

endmodule

>>> hdl/psfh_front.sv
module psfh_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  in_operation,
  input  logic signed [23:0]    in_species_code,
  input  logic signed [23:0]    in_mom_x,
  input  logic signed [23:0]    in_mom_y,
  input  logic [1:0]            in_read_species,
  input  logic [5:0]            in_read_bin,
  input  logic                  q_full,
  output logic                  q_push,
  output psfh_pkg::qword_t      q_word,
  output logic                  front_busy
);

  typedef enum logic [1:0] {F_IDLE, F_SQX, F_SQY, F_PUSH} fstate_t;

  fstate_t            state_r;
  psfh_pkg::qword_t   word_r;
  logic signed [23:0] mx_r, my_r;
  logic signed [47:0] prod;
  psfh_pkg::cls_t     cls;

  always_comb begin
    if (in_species_code == 24'sd211 || in_species_code == -24'sd211)
      cls = psfh_pkg::CLS_PION;
    else if (in_species_code == 24'sd321 || in_species_code == -24'sd321)
      cls = psfh_pkg::CLS_KAON;
    else if (in_species_code == 24'sd2112 || in_species_code == -24'sd2112 ||
             in_species_code == 24'sd2212 || in_species_code == -24'sd2212)
      cls = psfh_pkg::CLS_NUC;
    else
      cls = psfh_pkg::CLS_NONE;
  end

  assign prod       = (state_r == F_SQX) ? mx_r * mx_r : my_r * my_r;
  assign q_push     = (state_r == F_PUSH) && !q_full;
  assign q_word     = word_r;
  assign front_busy = (state_r != F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            word_r.op   <= psfh_pkg::op_t'(in_operation);
            word_r.cls  <= cls;
            word_r.rsp  <= in_read_species;
            word_r.rbin <= in_read_bin;
            mx_r        <= in_mom_x;
            my_r        <= in_mom_y;
            state_r     <= F_SQX;
          end
        end
        F_SQX: begin
          word_r.xx <= prod[psfh_pkg::SQ_W-1:0];
          state_r   <= F_SQY;
        end
        F_SQY: begin
          word_r.yy <= prod[psfh_pkg::SQ_W-1:0];
          state_r   <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/psfh_queue.sv
module psfh_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  psfh_pkg::qword_t push_word,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output psfh_pkg::qword_t pop_word
);

  psfh_pkg::qword_t ent_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_word = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

>>> hdl/psfh_back.sv
module psfh_back #(
  parameter int SPECTRA_BINS = psfh_pkg::SPECTRA_BINS_DEF,
  parameter int FLOW_BINS    = psfh_pkg::FLOW_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         spec_w,
  input  logic [15:0]         flow_w,
  input  logic                q_valid,
  input  psfh_pkg::qword_t    q_word,
  output logic                q_pop,
  output psfh_pkg::back_stat_t stat,
  output logic                out_valid,
  output logic [1:0]          out_class_found,
  output logic [31:0]         out_spectrum_count,
  output logic signed [47:0]  out_flow_sum,
  output logic [31:0]         out_flow_count,
  output logic [47:0]         out_mean_pt_sum,
  output logic [31:0]         out_mean_pt_count,
  output logic signed [47:0]  out_mean_flow_sum,
  output logic [31:0]         out_mean_flow_count
);

  localparam int SD   = 3 * SPECTRA_BINS;
  localparam int FD   = 3 * FLOW_BINS;
  localparam int SAW  = $clog2(SD);
  localparam int FAW  = $clog2(FD);
  localparam int MAXD = (SD > FD) ? SD : FD;
  localparam int CW   = $clog2(MAXD);

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_SQRT, B_DINIT, B_DIV, B_RADDR, B_UPD} bstate_t;

  bstate_t            state_r;
  logic [CW-1:0]      clr_cnt_r;
  logic [4:0]         cnt_r;
  psfh_pkg::qword_t   item_r;
  logic [47:0]        s_r, srem_r, res_r, bit_r;
  logic               inwin_r, neg_r, zero_r;
  logic [23:0]        sdq_r, fdq_r;
  logic [15:0]        srm_r, frm_r;
  logic [47:0]        crem_r;
  logic [48:0]        cden_r;
  logic [16:0]        cnum_r;
  logic signed [15:0] c_r;

  logic [31:0]        spec_mem [SD];
  logic signed [47:0] fsum_mem [FD];
  logic [31:0]        fcnt_mem [FD];
  logic [31:0]        spec_rd_r, fcnt_rd_r;
  logic signed [47:0] fsum_rd_r;

  logic [47:0]        wpt_sum_r  [3];
  logic [31:0]        wpt_cnt_r  [3];
  logic signed [47:0] wfl_sum_r  [3];
  logic [31:0]        wfl_cnt_r  [3];

  function automatic logic [31:0] inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic signed [47:0] sadd48(input logic signed [47:0] a,
                                                input logic signed [15:0] b);
    logic signed [48:0] r;
    logic signed [47:0] o;
    r = {a[47], a} + 49'(b);
    if (r[48] != r[47]) o = r[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else                o = r[47:0];
    return o;
  endfunction

  // sqrt step
  logic [47:0] trial;
  logic        sq_take;
  assign trial   = res_r + bit_r;
  assign sq_take = (srem_r >= trial);

  // bin division steps
  logic [16:0] st, ft;
  logic        s_take, f_take;
  assign st     = {srm_r, sdq_r[23]};
  assign ft     = {frm_r, fdq_r[23]};
  assign s_take = (st >= {1'b0, spec_w});
  assign f_take = (ft >= {1'b0, flow_w});

  // cos(2phi) division step
  logic [48:0] ct;
  logic        c_take;
  assign ct     = {crem_r, cnum_r[16]};
  assign c_take = (ct >= cden_r);

  // division setup
  logic [46:0] dmag;
  logic [63:0] cnum_full;
  assign dmag      = neg_r ? item_r.yy - item_r.xx : item_r.xx - item_r.yy;
  assign cnum_full = {1'b0, dmag, 16'd0} + 64'(s_r);

  // addressing
  logic           is_rd;
  logic [1:0]     sp;
  logic           spec_ok, flow_ok;
  logic [SAW-1:0] spec_addr, spec_wa;
  logic [FAW-1:0] flow_addr, flow_wa;
  logic           spec_we, flow_we, clearing;
  logic [31:0]    spec_wd, fcnt_wd;
  logic signed [47:0] fsum_wd;
  logic [1:0]     wsel;

  assign is_rd    = (item_r.op == psfh_pkg::OP_READ);
  assign sp       = is_rd ? item_r.rsp : item_r.cls;
  assign wsel     = (sp == 2'd3) ? 2'd0 : sp;
  assign clearing = (state_r == B_CLR);
  assign stat.clearing = clearing;

  always_comb begin
    if (is_rd) begin
      spec_ok = ({5'd0, item_r.rbin} < 11'(SPECTRA_BINS)) && (sp != 2'd3);
      flow_ok = ({5'd0, item_r.rbin} < 11'(FLOW_BINS)) && (sp != 2'd3);
    end else begin
      spec_ok = (spec_w != 16'd0) && (sdq_r < 24'(SPECTRA_BINS));
      flow_ok = (flow_w != 16'd0) && (fdq_r < 24'(FLOW_BINS));
    end
    if (spec_ok)
      spec_addr = SAW'(sp) * SAW'(SPECTRA_BINS) +
                  (is_rd ? SAW'(item_r.rbin) : SAW'(sdq_r));
    else
      spec_addr = '0;
    if (flow_ok)
      flow_addr = FAW'(sp) * FAW'(FLOW_BINS) +
                  (is_rd ? FAW'(item_r.rbin) : FAW'(fdq_r));
    else
      flow_addr = '0;
  end

  assign spec_we = clearing ? (int'(clr_cnt_r) < SD)
                            : (state_r == B_UPD && !is_rd && spec_ok);
  assign flow_we = clearing ? (int'(clr_cnt_r) < FD)
                            : (state_r == B_UPD && !is_rd && flow_ok);
  assign spec_wa = clearing ? clr_cnt_r[SAW-1:0] : spec_addr;
  assign flow_wa = clearing ? clr_cnt_r[FAW-1:0] : flow_addr;
  assign spec_wd = clearing ? 32'd0 : inc32(spec_rd_r);
  assign fcnt_wd = clearing ? 32'd0 : inc32(fcnt_rd_r);
  assign fsum_wd = clearing ? 48'sd0 : sadd48(fsum_rd_r, c_r);

  always_ff @(posedge clk) begin
    if (spec_we) spec_mem[spec_wa] <= spec_wd;
    spec_rd_r <= spec_mem[spec_addr];
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      fsum_mem[flow_wa] <= fsum_wd;
      fcnt_mem[flow_wa] <= fcnt_wd;
    end
    fsum_rd_r <= fsum_mem[flow_addr];
    fcnt_rd_r <= fcnt_mem[flow_addr];
  end

  assign q_pop = (state_r == B_IDLE) && q_valid;

  logic [47:0] s_in;
  logic [48:0] pt_acc;
  assign s_in   = {1'b0, q_word.xx} + {1'b0, q_word.yy};
  assign pt_acc = {1'b0, wpt_sum_r[wsel]} + 49'(res_r[23:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_CLR;
      clr_cnt_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        wpt_sum_r[i] <= '0;
        wpt_cnt_r[i] <= '0;
        wfl_sum_r[i] <= '0;
        wfl_cnt_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        B_CLR: begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
          if (clr_cnt_r == CW'(MAXD - 1)) state_r <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            item_r  <= q_word;
            s_r     <= s_in;
            srem_r  <= s_in;
            res_r   <= '0;
            bit_r   <= 48'd1 << 46;
            cnt_r   <= 5'd23;
            inwin_r <= (s_in > psfh_pkg::win_lo_sq(q_word.cls)) &&
                       (s_in < psfh_pkg::win_hi_sq(q_word.cls));
            neg_r   <= (q_word.yy > q_word.xx);
            zero_r  <= (s_in == 48'd0);
            if (q_word.op == psfh_pkg::OP_READ) begin
              state_r <= B_RADDR;
            end else if (q_word.cls == psfh_pkg::CLS_NONE) begin
              out_valid           <= 1'b1;
              out_class_found     <= psfh_pkg::CLS_NONE;
              out_spectrum_count  <= '0;
              out_flow_sum        <= '0;
              out_flow_count      <= '0;
              out_mean_pt_sum     <= '0;
              out_mean_pt_count   <= '0;
              out_mean_flow_sum   <= '0;
              out_mean_flow_count <= '0;
            end else begin
              state_r <= B_SQRT;
            end
          end
        end
        B_SQRT: begin
          if (sq_take) begin
            srem_r <= srem_r - trial;
            res_r  <= (res_r >> 1) + bit_r;
          end else begin
            res_r  <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= B_DINIT;
        end
        B_DINIT: begin
          sdq_r   <= res_r[23:0];
          fdq_r   <= res_r[23:0];
          srm_r   <= '0;
          frm_r   <= '0;
          crem_r  <= {1'b0, cnum_full[63:17]};
          cnum_r  <= cnum_full[16:0];
          cden_r  <= {s_r, 1'b0};
          cnt_r   <= 5'd23;
          state_r <= B_DIV;
        end
        B_DIV: begin
          srm_r <= s_take ? 16'(st - {1'b0, spec_w}) : st[15:0];
          sdq_r <= {sdq_r[22:0], s_take};
          frm_r <= f_take ? 16'(ft - {1'b0, flow_w}) : ft[15:0];
          fdq_r <= {fdq_r[22:0], f_take};
          if (cnt_r >= 5'd7) begin
            crem_r <= c_take ? 48'(ct - cden_r) : ct[47:0];
            cnum_r <= {cnum_r[15:0], c_take};
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= B_RADDR;
        end
        B_RADDR: begin
          if (zero_r)       c_r <= 16'sh7FFF;
          else if (neg_r)   c_r <= 16'(-cnum_r);
          else if (cnum_r[15] || cnum_r[16]) c_r <= 16'sh7FFF;
          else              c_r <= 16'(cnum_r);
          state_r <= B_UPD;
        end
        B_UPD: begin
          out_valid <= 1'b1;
          if (is_rd) begin
            out_class_found <= item_r.rsp;
            if (sp == 2'd3) begin
              out_spectrum_count  <= '0;
              out_flow_sum        <= '0;
              out_flow_count      <= '0;
              out_mean_pt_sum     <= '0;
              out_mean_pt_count   <= '0;
              out_mean_flow_sum   <= '0;
              out_mean_flow_count <= '0;
            end else begin
              out_spectrum_count  <= spec_ok ? spec_rd_r : 32'd0;
              out_flow_sum        <= flow_ok ? fsum_rd_r : 48'sd0;
              out_flow_count      <= flow_ok ? fcnt_rd_r : 32'd0;
              out_mean_pt_sum     <= wpt_sum_r[wsel];
              out_mean_pt_count   <= wpt_cnt_r[wsel];
              out_mean_flow_sum   <= wfl_sum_r[wsel];
              out_mean_flow_count <= wfl_cnt_r[wsel];
            end
          end else begin
            out_class_found     <= item_r.cls;
            out_spectrum_count  <= '0;
            out_flow_sum        <= '0;
            out_flow_count      <= '0;
            out_mean_pt_sum     <= '0;
            out_mean_pt_count   <= '0;
            out_mean_flow_sum   <= '0;
            out_mean_flow_count <= '0;
            if (spec_ok && inwin_r) begin
              wpt_sum_r[wsel] <= pt_acc[48] ? {48{1'b1}} : pt_acc[47:0];
              wpt_cnt_r[wsel] <= inc32(wpt_cnt_r[wsel]);
            end
            if (flow_ok && inwin_r) begin
              wfl_sum_r[wsel] <= sadd48(wfl_sum_r[wsel], c_r);
              wfl_cnt_r[wsel] <= inc32(wfl_cnt_r[wsel]);
            end
          end
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb_particle_spectra_flow_histogrammer.sv
`timescale 1ns / 1ps

module tb_particle_spectra_flow_histogrammer;

  localparam int NSB = psfh_pkg::SPECTRA_BINS_DEF;
  localparam int NFB = psfh_pkg::FLOW_BINS_DEF;
  localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [1:0]         cls;
    logic [31:0]        spec_cnt;
    logic signed [47:0] fsum;
    logic [31:0]        fcnt;
    logic [47:0]        pt_sum;
    logic [31:0]        pt_cnt;
    logic signed [47:0] wf_sum;
    logic [31:0]        wf_cnt;
  } hist_word_t;

  typedef struct {
    logic               op;
    logic signed [23:0] code;
    logic signed [23:0] mx;
    logic signed [23:0] my;
    logic [1:0]         rsp;
    logic [5:0]         rbin;
    logic               known;
    hist_word_t         exp;
  } stim_row_t;

  logic clk, rst_n, start, busy;
  logic in_operation;
  logic signed [23:0] in_species_code, in_mom_x, in_mom_y;
  logic [1:0] in_read_species;
  logic [5:0] in_read_bin;
  logic out_valid;
  logic [1:0] out_class_found;
  logic [31:0] out_spectrum_count, out_flow_count, out_mean_pt_count, out_mean_flow_count;
  logic signed [47:0] out_flow_sum, out_mean_flow_sum;
  logic [47:0] out_mean_pt_sum;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [15:0] cfg_wdata;

  particle_spectra_flow_histogrammer u_top (.*);

  logic [15:0] spec_w, flow_w;
  logic [31:0] spec_hist [3*NSB];
  logic [47:0] fh_sum [3*NFB];
  logic [31:0] fh_cnt [3*NFB];
  logic [47:0] w_pt_sum [3];
  logic [31:0] w_pt_cnt [3];
  logic [47:0] w_f_sum [3];
  logic [31:0] w_f_cnt [3];

  hist_word_t pending_words [$];
  int errors = 0;
  int idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_particle_spectra_flow_histogrammer: FAIL");
    $finish;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [47:0] sat_add_s48(logic [47:0] a, logic signed [16:0] v);
    logic signed [49:0] r;
    r = $signed({{2{a[47]}}, a}) + v;
    if (r > $signed({2'b00, S48_MAX})) return S48_MAX;
    if (r < $signed({2'b11, S48_MIN})) return S48_MIN;
    return r[47:0];
  endfunction

  function automatic logic [1:0] species_of(logic signed [23:0] code);
    logic [23:0] a;
    a = code[23] ? -code : code;
    if (a == 24'd211) return psfh_pkg::CLS_PION;
    if (a == 24'd321) return psfh_pkg::CLS_KAON;
    if (a == 24'd2112 || a == 24'd2212) return psfh_pkg::CLS_NUC;
    return psfh_pkg::CLS_NONE;
  endfunction

  function automatic logic [23:0] int_sqrt(logic [47:0] s);
    logic [47:0] res, bitv, rem;
    res = '0;
    rem = s;
    bitv = 48'h1 << 46;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[23:0];
  endfunction

  function automatic logic signed [16:0] cos_two_phi(logic [47:0] xx, logic [47:0] yy);
    logic [63:0] s, d, q;
    logic signed [17:0] c;
    s = 64'(xx) + 64'(yy);
    if (s == 0) return 17'sd32767;
    d = (yy > xx) ? 64'(yy - xx) : 64'(xx - yy);
    q = (64'd2 * d * 64'd32768 + s) / (64'd2 * s);
    c = (yy > xx) ? -$signed({1'b0, q[16:0]}) : $signed({1'b0, q[16:0]});
    if (c > 18'sd32767) c = 18'sd32767;
    if (c < -18'sd32768) c = -18'sd32768;
    return c[16:0];
  endfunction

  function automatic hist_word_t predict_word(stim_row_t r);
    hist_word_t w;
    logic [1:0] sp;
    logic signed [47:0] mxe, mye;
    logic [47:0] xx, yy, s;
    logic [23:0] pt;
    logic [47:0] lo, hi;
    logic inwin;
    logic signed [16:0] c;
    int b, k;
    logic [48:0] ps;
    w = '0;
    if (r.op == psfh_pkg::OP_ACC) begin
      sp = species_of(r.code);
      w.cls = sp;
      if (sp == psfh_pkg::CLS_NONE) return w;
      mxe = r.mx;
      mye = r.my;
      xx = mxe * mxe;
      yy = mye * mye;
      s = xx + yy;
      pt = int_sqrt(s);
      lo = (sp == psfh_pkg::CLS_NUC) ? 48'd2048 : 48'd819;
      hi = (sp == psfh_pkg::CLS_NUC) ? 48'd10240 : 48'd8192;
      inwin = s > lo * lo && s < hi * hi;
      if (spec_w != 0) begin
        b = int'(pt / spec_w);
        if (b < NSB) begin
          k = sp * NSB + b;
          spec_hist[k] = sat_inc(spec_hist[k]);
          if (inwin) begin
            ps = w_pt_sum[sp] + pt;
            w_pt_sum[sp] = ps[48] ? 48'hFFFF_FFFF_FFFF : ps[47:0];
            w_pt_cnt[sp] = sat_inc(w_pt_cnt[sp]);
          end
        end
      end
      if (flow_w != 0) begin
        b = int'(pt / flow_w);
        if (b < NFB) begin
          c = cos_two_phi(xx, yy);
          k = sp * NFB + b;
          fh_sum[k] = sat_add_s48(fh_sum[k], c);
          fh_cnt[k] = sat_inc(fh_cnt[k]);
          if (inwin) begin
            w_f_sum[sp] = sat_add_s48(w_f_sum[sp], c);
            w_f_cnt[sp] = sat_inc(w_f_cnt[sp]);
          end
        end
      end
    end else begin
      sp = r.rsp;
      w.cls = sp;
      if (sp == psfh_pkg::CLS_NONE) return w;
      if (r.rbin < NSB) w.spec_cnt = spec_hist[sp * NSB + r.rbin];
      if (r.rbin < NFB) begin
        w.fsum = fh_sum[sp * NFB + r.rbin];
        w.fcnt = fh_cnt[sp * NFB + r.rbin];
      end
      w.pt_sum = w_pt_sum[sp];
      w.pt_cnt = w_pt_cnt[sp];
      w.wf_sum = w_f_sum[sp];
      w.wf_cnt = w_f_cnt[sp];
    end
    return w;
  endfunction

  always @(posedge clk) begin
    hist_word_t e;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_class_found !== e.cls) begin
          $error("class_found exp %0d got %0d", e.cls, out_class_found); errors++;
        end
        if (out_spectrum_count !== e.spec_cnt) begin
          $error("spectrum_count exp %0d got %0d", e.spec_cnt, out_spectrum_count); errors++;
        end
        if (out_flow_sum !== e.fsum) begin
          $error("flow_sum exp %0d got %0d", e.fsum, out_flow_sum); errors++;
        end
        if (out_flow_count !== e.fcnt) begin
          $error("flow_count exp %0d got %0d", e.fcnt, out_flow_count); errors++;
        end
        if (out_mean_pt_sum !== e.pt_sum) begin
          $error("mean_pt_sum exp %0d got %0d", e.pt_sum, out_mean_pt_sum); errors++;
        end
        if (out_mean_pt_count !== e.pt_cnt) begin
          $error("mean_pt_count exp %0d got %0d", e.pt_cnt, out_mean_pt_count); errors++;
        end
        if (out_mean_flow_sum !== e.wf_sum) begin
          $error("mean_flow_sum exp %0d got %0d", e.wf_sum, out_mean_flow_sum); errors++;
        end
        if (out_mean_flow_count !== e.wf_cnt) begin
          $error("mean_flow_count exp %0d got %0d", e.wf_cnt, out_mean_flow_count); errors++;
        end
      end
    end
  end

  task automatic send_word(stim_row_t r);
    hist_word_t w;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= r.op;
    in_species_code <= r.code;
    in_mom_x <= r.mx;
    in_mom_y <= r.my;
    in_read_species <= r.rsp;
    in_read_bin <= r.rbin;
    @(posedge clk);
    while (busy) @(posedge clk);
    w = predict_word(r);
    if (r.known && w !== r.exp) begin
      $error("directed row exp %h predictor %h", r.exp, w);
      errors++;
    end
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_width(psfh_pkg::cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == psfh_pkg::CFG_SPEC_W) spec_w = v;
    else flow_w = v;
    @(posedge clk);
  endtask

  function automatic stim_row_t acc_row(logic signed [23:0] code, logic signed [23:0] mx,
                                        logic signed [23:0] my);
    stim_row_t r;
    r = '{psfh_pkg::OP_ACC, code, mx, my, 2'd0, 6'd0, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t read_row(logic [1:0] sp, logic [5:0] b);
    stim_row_t r;
    r = '{psfh_pkg::OP_READ, 24'sd0, 24'sd0, 24'sd0, sp, b, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int codes [8] = '{211, -211, 321, -321, 2112, -2112, 2212, -2212};
    int m;
    if ($urandom_range(3) == 0) begin
      r = read_row(2'($urandom_range(3)), 6'($urandom));
    end else begin
      m = $urandom_range(9);
      r = acc_row(m == 0 ? 24'($urandom) : 24'(codes[$urandom_range(7)]),
                  m < 2 ? 24'($urandom) : 24'($signed($urandom_range(24000)) - 12000),
                  m < 2 ? 24'($urandom) : 24'($signed($urandom_range(24000)) - 12000));
    end
    return r;
  endfunction

  initial begin
    stim_row_t dir [$];
    stim_row_t r;
    hist_word_t z;
    int pcts [4] = '{0, 83, 0, 12};
    start = 1'b0; in_operation = 1'b0; in_species_code = '0; in_mom_x = '0; in_mom_y = '0;
    in_read_species = '0; in_read_bin = '0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    rst_n = 1'b0;
    spec_w = psfh_pkg::SPEC_W_RST;
    flow_w = psfh_pkg::FLOW_W_RST;
    foreach (spec_hist[i]) spec_hist[i] = '0;
    foreach (fh_sum[i]) begin fh_sum[i] = '0; fh_cnt[i] = '0; end
    foreach (w_pt_sum[i]) begin
      w_pt_sum[i] = '0; w_pt_cnt[i] = '0; w_f_sum[i] = '0; w_f_cnt[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset every read is zero, and a particle of unknown species returns zero
    z = '0;
    r = read_row(psfh_pkg::CLS_PION, 6'd0); r.known = 1'b1; r.exp = z;
    dir.insert(dir.size(), r);
    r = read_row(psfh_pkg::CLS_NUC, 6'd63); r.known = 1'b1; z.cls = psfh_pkg::CLS_NUC;
    r.exp = z; dir.insert(dir.size(), r);
    r = read_row(psfh_pkg::CLS_NONE, 6'd5); r.known = 1'b1; z.cls = psfh_pkg::CLS_NONE;
    r.exp = z; dir.insert(dir.size(), r);
    r = acc_row(24'sd999, 24'sd100, 24'sd100); r.known = 1'b1; r.exp = z;
    dir.insert(dir.size(), r);
    r = acc_row(-24'sd8388608, -24'sd8388608, 24'sd8388607); r.known = 1'b1; r.exp = z;
    dir.insert(dir.size(), r);
    dir.insert(dir.size(), acc_row(24'sd211, 24'sd0, 24'sd0));
    dir.insert(dir.size(), acc_row(-24'sd211, 24'sd3000, 24'sd0));
    dir.insert(dir.size(), acc_row(24'sd321, 24'sd0, -24'sd3000));
    dir.insert(dir.size(), acc_row(24'sd2112, 24'sd2048, 24'sd0));
    dir.insert(dir.size(), acc_row(-24'sd2212, 24'sd10239, 24'sd0));
    dir.insert(dir.size(), acc_row(24'sd211, 24'sd819, 24'sd0));
    dir.insert(dir.size(), acc_row(24'sd211, 24'sd820, 24'sd1));
    dir.insert(dir.size(), acc_row(24'sd321, -24'sd8388608, -24'sd8388608));
    dir.insert(dir.size(), acc_row(24'sd2212, 24'sd8388607, 24'sd1));
    dir.insert(dir.size(), acc_row(24'sd211, 24'sd5, 24'sd5));
    dir.insert(dir.size(), read_row(psfh_pkg::CLS_PION, 6'd0));
    dir.insert(dir.size(), read_row(psfh_pkg::CLS_PION, 6'd7));
    dir.insert(dir.size(), read_row(psfh_pkg::CLS_KAON, 6'd7));
    dir.insert(dir.size(), read_row(psfh_pkg::CLS_NUC, 6'd5));
    dir.insert(dir.size(), read_row(psfh_pkg::CLS_NUC, 6'd40));
    foreach (dir[i]) send_word(dir[i]);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        1: begin
          write_width(psfh_pkg::CFG_SPEC_W, 16'd1);
          write_width(psfh_pkg::CFG_FLOW_W, 16'hFFFF);
        end
        2: begin
          write_width(psfh_pkg::CFG_SPEC_W, 16'hFFFF);
          write_width(psfh_pkg::CFG_FLOW_W, 16'd1);
        end
        3: begin
          write_width(psfh_pkg::CFG_SPEC_W, 16'd0);
          write_width(psfh_pkg::CFG_FLOW_W, 16'd300);
        end
        4: begin
          write_width(psfh_pkg::CFG_SPEC_W, 16'd200);
          write_width(psfh_pkg::CFG_FLOW_W, 16'd0);
        end
        5: begin
          write_width(psfh_pkg::CFG_SPEC_W, 16'($urandom_range(1, 600)));
          write_width(psfh_pkg::CFG_FLOW_W, 16'($urandom_range(1, 900)));
        end
        6: begin
          write_width(psfh_pkg::CFG_SPEC_W, psfh_pkg::SPEC_W_RST);
          write_width(psfh_pkg::CFG_FLOW_W, psfh_pkg::FLOW_W_RST);
        end
        default: ;
      endcase
      for (int q = 0; q < 4; q++) begin
        idle_pct = pcts[q];
        for (int n = 0; n < 37; n++) send_word(rand_row());
      end
      idle_pct = 0;
      for (int b = 0; b < 3; b++) send_word(read_row(2'(b), 6'($urandom)));
      drain();
    end

    if (errors == 0) begin
      $display("tb_particle_spectra_flow_histogrammer: PASS");
    end else begin
      $display("tb_particle_spectra_flow_histogrammer: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/psfh_pkg.sv
hdl/psfh_front.sv
hdl/psfh_queue.sv
hdl/psfh_back.sv
hdl/particle_spectra_flow_histogrammer.sv
tb/tb_particle_spectra_flow_histogrammer.sv
